// ===== src/tucc_pkg.sv =====
// ----------------------------------------------------------------------------
// tucc_pkg
// shared types and constants of the tile unique color checker
// ----------------------------------------------------------------------------
package tucc_pkg;

  // fixed field widths
  localparam int unsigned ColorW   = 24;
  localparam int unsigned TprW     = 9;
  localparam int unsigned TileNumW = 16;
  localparam int unsigned TilePosW = 8;

  // apb port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // register indexes, byte address is 4 * index
  typedef enum logic {
    REG_TRANSPARENT   = 1'b0,
    REG_TILES_PER_ROW = 1'b1
  } reg_idx_e;

  // request into the color set, one per processed pixel
  typedef struct packed {
    logic              take;   // pixel is processed this cycle
    logic              clear;  // pixel is the last of its tile
    logic [ColorW-1:0] color;
  } set_req_t;

endpackage

// ===== src/tucc_color_set.sv =====
// ----------------------------------------------------------------------------
// tucc_color_set
// distinct color set of the current tile with parallel compare and insert
// ----------------------------------------------------------------------------
module tucc_color_set #(
  parameter int unsigned PALETTE_COLORS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  tucc_pkg::set_req_t                       req_i,
  input  logic [tucc_pkg::ColorW-1:0]              transparent_i,
  output logic [$clog2(PALETTE_COLORS+2)-1:0]      count_o
);

  localparam int unsigned CntW = $clog2(PALETTE_COLORS + 2);
  localparam int unsigned IdxW = $clog2(PALETTE_COLORS);

  logic [tucc_pkg::ColorW-1:0] seen_q [PALETTE_COLORS];
  logic [CntW-1:0]             count_q;
  logic [CntW-1:0]             count_d;
  logic                        hit;
  logic                        ignore;
  logic                        store;

  // compare against every stored entry below the fill count
  always_comb begin
    hit = 1'b0;
    for (int unsigned i = 0; i < PALETTE_COLORS; i++) begin
      if ((CntW'(i) < count_q) && (seen_q[i] == req_i.color)) begin
        hit = 1'b1;
      end
    end
  end

  // new color decision, count saturates one above the palette size
  assign ignore  = (req_i.color == transparent_i) ||
                   (count_q > CntW'(PALETTE_COLORS)) || hit;
  assign count_d = ignore ? count_q : count_q + CntW'(1);
  assign store   = req_i.take && !ignore && (count_q < CntW'(PALETTE_COLORS));
  assign count_o = count_d;

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (req_i.take) begin
      count_q <= req_i.clear ? '0 : count_d;
    end
  end

  // set entries, read only below the fill count
  always_ff @(posedge clk_i) begin
    if (store) begin
      seen_q[count_q[IdxW-1:0]] <= req_i.color;
    end
  end

endmodule

// ===== src/tile_unique_color_checker.sv =====
// ----------------------------------------------------------------------------
// tile_unique_color_checker
// counts distinct non-transparent colors per square tile of a pixel stream
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid_i / pixel_stall_o), tile
// after tile, each tile in row-major order. One result per finished tile
// leaves on the result channel (result_valid_o / result_stall_i) with the
// tile number, tile row and column, the distinct color count and the
// too-many-colors flag. The APB port holds the transparent color (0x0) and
// the image width in tiles (0x4); write them only while the block is idle.
// Throughput is one pixel per cycle while no tile's last pixel waits on a
// stalled result: the compare against the set registers is combinational.
// A tile's result is set in the result register, behind the input register.
// Reset empties the set, clears the tile counters and sets the registers to
// transparent color 0 and one tile per row. While the result is stalled,
// pixels keep flowing until the last pixel of the next tile, which waits in
// the input register and stalls the pixel channel.
// ----------------------------------------------------------------------------
module tile_unique_color_checker #(
  parameter int unsigned TILE_SIDE      = 8,
  parameter int unsigned PALETTE_COLORS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // apb configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tucc_pkg::AddrW-1:0]            paddr,
  input  logic [tucc_pkg::DataW-1:0]            pwdata,
  output logic [tucc_pkg::DataW-1:0]            prdata,
  output logic                                  pready,
  // pixel channel
  input  logic                                  pixel_valid_i,
  output logic                                  pixel_stall_o,
  input  logic [tucc_pkg::ColorW-1:0]           pixel_color_i,
  // result channel
  output logic                                  result_valid_o,
  input  logic                                  result_stall_i,
  output logic [tucc_pkg::TileNumW-1:0]         tile_number_o,
  output logic [tucc_pkg::TilePosW-1:0]         tile_row_o,
  output logic [tucc_pkg::TilePosW-1:0]         tile_column_o,
  output logic [$clog2(PALETTE_COLORS+2)-1:0]   color_count_o,
  output logic                                  too_many_colors_o
);

  localparam int unsigned TilePixels = TILE_SIDE * TILE_SIDE;
  localparam int unsigned PosW       = $clog2(TilePixels);
  localparam int unsigned CntW       = $clog2(PALETTE_COLORS + 2);

  // configuration registers
  logic [tucc_pkg::ColorW-1:0]   transparent_q;
  logic [tucc_pkg::TprW-1:0]     tiles_per_row_q;
  tucc_pkg::reg_idx_e            reg_idx;
  logic                          cfg_write;

  // input register
  logic                          pix_valid_q;
  logic [tucc_pkg::ColorW-1:0]   pix_color_q;

  // tile tracking
  logic [PosW-1:0]               pos_q;
  logic [tucc_pkg::TileNumW-1:0] tile_num_q;
  logic [tucc_pkg::TilePosW-1:0] tile_row_q;
  logic [tucc_pkg::TilePosW-1:0] tile_col_q;
  logic [tucc_pkg::TprW-1:0]     next_col;
  logic                          row_wrap;

  // processing control
  logic                          last_pix;
  logic                          out_free;
  logic                          advance;
  tucc_pkg::set_req_t            set_req;
  logic [CntW-1:0]               set_count;

  // result register
  logic                          res_valid_q;
  logic [tucc_pkg::TileNumW-1:0] res_num_q;
  logic [tucc_pkg::TilePosW-1:0] res_row_q;
  logic [tucc_pkg::TilePosW-1:0] res_col_q;
  logic [CntW-1:0]               res_count_q;
  logic                          res_flag_q;

  // apb decode, word aligned
  assign pready    = 1'b1;
  assign reg_idx   = tucc_pkg::reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tucc_pkg::REG_TRANSPARENT:   prdata = tucc_pkg::DataW'(transparent_q);
      tucc_pkg::REG_TILES_PER_ROW: prdata = tucc_pkg::DataW'(tiles_per_row_q);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transparent_q   <= '0;
      tiles_per_row_q <= tucc_pkg::TprW'(1);
    end else if (cfg_write) begin
      unique case (reg_idx)
        tucc_pkg::REG_TRANSPARENT:   transparent_q   <= pwdata[tucc_pkg::ColorW-1:0];
        tucc_pkg::REG_TILES_PER_ROW: tiles_per_row_q <= pwdata[tucc_pkg::TprW-1:0];
        default: ;
      endcase
    end
  end

  // flow control: only a tile's last pixel waits for the result register
  assign last_pix      = (pos_q == PosW'(TilePixels - 1));
  assign out_free      = !res_valid_q || !result_stall_i;
  assign advance       = pix_valid_q && (!last_pix || out_free);
  assign pixel_stall_o = pix_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (!pixel_stall_o) begin
      pix_valid_q <= pixel_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pixel_stall_o) begin
      pix_color_q <= pixel_color_i;
    end
  end

  // color set
  assign set_req.take  = advance;
  assign set_req.clear = last_pix;
  assign set_req.color = pix_color_q;

  tucc_color_set #(
    .PALETTE_COLORS(PALETTE_COLORS)
  ) u_color_set (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (set_req),
    .transparent_i(transparent_q),
    .count_o      (set_count)
  );

  // tile position, column wraps at the image width or at 8 bits
  assign next_col = {1'b0, tile_col_q} + tucc_pkg::TprW'(1);
  assign row_wrap = (tile_col_q == '1) || (next_col >= tiles_per_row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      tile_num_q <= '0;
      tile_row_q <= '0;
      tile_col_q <= '0;
    end else if (advance) begin
      if (last_pix) begin
        pos_q      <= '0;
        tile_num_q <= tile_num_q + tucc_pkg::TileNumW'(1);
        if (row_wrap) begin
          tile_col_q <= '0;
          tile_row_q <= tile_row_q + tucc_pkg::TilePosW'(1);
        end else begin
          tile_col_q <= next_col[tucc_pkg::TilePosW-1:0];
        end
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && last_pix) begin
      res_valid_q <= 1'b1;
    end else if (!result_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_pix) begin
      res_num_q   <= tile_num_q;
      res_row_q   <= tile_row_q;
      res_col_q   <= tile_col_q;
      res_count_q <= set_count;
      res_flag_q  <= (set_count > CntW'(PALETTE_COLORS));
    end
  end

  assign result_valid_o    = res_valid_q;
  assign tile_number_o     = res_num_q;
  assign tile_row_o        = res_row_q;
  assign tile_column_o     = res_col_q;
  assign color_count_o     = res_count_q;
  assign too_many_colors_o = res_flag_q;

endmodule

// ===== src/tucc_checker.sv =====
// ----------------------------------------------------------------------------
// tucc_checker
// port level checks of the tile unique color checker
// ----------------------------------------------------------------------------
module tucc_checker #(
  parameter int unsigned PALETTE_COLORS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                result_valid_o,
  input logic                                result_stall_i,
  input logic [tucc_pkg::TileNumW-1:0]       tile_number_o,
  input logic [$clog2(PALETTE_COLORS+2)-1:0] color_count_o,
  input logic                                too_many_colors_o
);

  localparam int unsigned CntW = $clog2(PALETTE_COLORS + 2);

  // a stalled result keeps its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(tile_number_o))
    else $error("stalled result dropped or changed");

  // count saturates one above the palette size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> color_count_o <= CntW'(PALETTE_COLORS + 1))
    else $error("color count above saturation");

  // flag goes with the saturated count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> too_many_colors_o == (color_count_o == CntW'(PALETTE_COLORS + 1)))
    else $error("overflow flag disagrees with count");

  // back to back results carry consecutive tile numbers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_stall_i) ##1 result_valid_o |->
      tile_number_o == $past(tile_number_o) + tucc_pkg::TileNumW'(1))
    else $error("tile number skipped");

endmodule

bind tile_unique_color_checker tucc_checker #(
  .PALETTE_COLORS(PALETTE_COLORS)
) u_tucc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .result_valid_o   (result_valid_o),
  .result_stall_i   (result_stall_i),
  .tile_number_o    (tile_number_o),
  .color_count_o    (color_count_o),
  .too_many_colors_o(too_many_colors_o)
);
